[hdl/erc_pkg.sv]
// ----------------------------------------------------------------------------
// erc_pkg
// Types, codes and helper functions for the bootloader reply checker.
// ----------------------------------------------------------------------------
package erc_pkg;

   // byte store depth; bytes beyond it are dropped and the index holds
   localparam int STORE_BYTES = 64;
   localparam int INDEX_W     = $clog2(STORE_BYTES + 1);

   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [2:0]         kind_type;
   typedef logic [1:0]         status_type;
   typedef logic [7:0]         byte_type;
   typedef logic [31:0]        word_type;

   // beat modes
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_BYTE  = 1'b1;

   // reply kinds
   localparam kind_type KIND_PROBE  = 3'd0;
   localparam kind_type KIND_INFO   = 3'd1;
   localparam kind_type KIND_READ   = 3'd2;
   localparam kind_type KIND_WRITE  = 3'd3;
   localparam kind_type KIND_BWRITE = 3'd4;
   localparam kind_type KIND_TEXT   = 3'd5;

   // result status codes
   localparam status_type ST_IDLE = 2'd0;
   localparam status_type ST_WAIT = 2'd1;
   localparam status_type ST_OK   = 2'd2;
   localparam status_type ST_ERR  = 2'd3;

   typedef enum logic [3:0] {
      RS_IDLE,
      RS_PROBE,
      RS_INFO,
      RS_READ,
      RS_WRITE,
      RS_BWRITE,
      RS_TEXT,
      RS_OK,
      RS_ERROR
   } reply_state_type;

   // reply layout
   localparam int PAYLOAD_START = 2;
   localparam int INFO_PAYLOAD  = 32;
   localparam int READ_PAYLOAD  = 20;
   localparam int CRC_BYTES     = 4;
   localparam int BIN_END       = 2;
   localparam int INFO_END      = PAYLOAD_START + INFO_PAYLOAD + CRC_BYTES;
   localparam int READ_END      = PAYLOAD_START + READ_PAYLOAD + CRC_BYTES;
   localparam int INFO_CRC_END  = PAYLOAD_START + INFO_PAYLOAD;
   localparam int READ_CRC_END  = PAYLOAD_START + READ_PAYLOAD;
   localparam int OK_END        = 3;
   localparam int LINE_END      = 14;

   localparam byte_type PAIR_BAD   = 8'hff;
   localparam byte_type STATUS_OK  = 8'h00;
   localparam byte_type INFO_COUNT = 8'd7;
   localparam byte_type READ_COUNT = 8'd4;
   localparam byte_type READ_TAG0  = 8'hea;
   localparam byte_type READ_TAG1  = 8'h32;

   // leading reply bytes kept for the checks and field extraction
   localparam int CAPTURE_BYTES = 8;
   localparam int CAP_IDX_W     = $clog2(CAPTURE_BYTES);
   // bytes held back for the received crc word
   localparam int HIST_W        = 8 * (CRC_BYTES - 1);

   localparam word_type CRC_INIT = 32'hffff_ffff;
   localparam word_type CRC_POLY = 32'hedb8_8320;

   // characters
   localparam byte_type CH_NUL   = 8'h00;
   localparam byte_type CH_TAB   = 8'h09;
   localparam byte_type CH_LF    = 8'h0a;
   localparam byte_type CH_VT    = 8'h0b;
   localparam byte_type CH_FF    = 8'h0c;
   localparam byte_type CH_CR    = 8'h0d;
   localparam byte_type CH_SPACE = 8'h20;
   localparam byte_type CH_PLUS  = 8'h2b;
   localparam byte_type CH_MINUS = 8'h2d;
   localparam byte_type CH_ZERO  = 8'h30;
   localparam byte_type CH_NINE  = 8'h39;
   localparam byte_type CH_O     = 8'h4f;
   localparam byte_type CH_K     = 8'h4b;

   // setting keywords
   localparam int KW_INPUT_LEN = 7;
   localparam int KW_TELEM_LEN = 7;
   localparam int KW_PHID_LEN  = 10;
   localparam logic [8*KW_INPUT_LEN-1:0] KW_INPUT = "input_m";
   localparam logic [8*KW_TELEM_LEN-1:0] KW_TELEM = "telem_m";
   // telemetry identifier keyword, ascii bytes first character first
   localparam logic [8*KW_PHID_LEN-1:0]  KW_PHID  = 80'h74_65_6c_65_6d_5f_70_68_69_64;

   localparam byte_type NUM_SAT  = 8'd254;
   localparam byte_type NUM_NONE = 8'd255;
   localparam int       ACC_W    = 12;

   localparam int TOK_W = $clog2(LINE_END + 1);

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_TOKEN,
      PH_SEP,
      PH_SIGNED,
      PH_DIGITS,
      PH_DONE
   } parse_phase_type;

   typedef struct packed {
      parse_phase_type   phase;
      logic [TOK_W-1:0]  tok_len;
      logic              hit_input;
      logic              hit_telem;
      logic              hit_phid;
      logic              neg;
      logic              digits;
      byte_type          val;
   } parse_type;

   localparam parse_type PARSE_RESET = '{
      phase:     PH_LEAD,
      tok_len:   '0,
      hit_input: 1'b1,
      hit_telem: 1'b1,
      hit_phid:  1'b1,
      neg:       1'b0,
      digits:    1'b0,
      val:       '0
   };

   function automatic reply_state_type kind_state(kind_type k);
      reply_state_type r;
      case (k)
         KIND_PROBE:  r = RS_PROBE;
         KIND_INFO:   r = RS_INFO;
         KIND_READ:   r = RS_READ;
         KIND_WRITE:  r = RS_WRITE;
         KIND_BWRITE: r = RS_BWRITE;
         KIND_TEXT:   r = RS_TEXT;
         default:     r = RS_IDLE;
      endcase
      return r;
   endfunction

   function automatic word_type crc_byte(word_type crc, byte_type b);
      word_type c;
      c = crc ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic is_space(byte_type c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
             c == CH_FF || c == CH_CR;
   endfunction

   function automatic logic is_digit(byte_type c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   // count and complement pair holding the expected count
   function automatic logic pair_ok(byte_type a, byte_type b, byte_type count);
      return ((a ^ b) == PAIR_BAD) && (a == count);
   endfunction

   function automatic byte_type sat_digit(byte_type val, byte_type c);
      logic [ACC_W-1:0] acc;
      acc = ACC_W'(val) * ACC_W'(10) + ACC_W'(c - CH_ZERO);
      return (acc > ACC_W'(NUM_SAT)) ? NUM_NONE : acc[7:0];
   endfunction

   // keyword prefix match, one token character at a time
   function automatic parse_type match_char(parse_type p, byte_type c);
      parse_type q;
      int        t;
      q = p;
      t = int'(p.tok_len);
      if (t < KW_INPUT_LEN) begin
         q.hit_input = p.hit_input && (c == KW_INPUT[8*(KW_INPUT_LEN-1-t) +: 8]);
      end
      if (t < KW_TELEM_LEN) begin
         q.hit_telem = p.hit_telem && (c == KW_TELEM[8*(KW_TELEM_LEN-1-t) +: 8]);
      end
      if (t < KW_PHID_LEN) begin
         q.hit_phid = p.hit_phid && (c == KW_PHID[8*(KW_PHID_LEN-1-t) +: 8]);
      end
      if (t < LINE_END) begin
         q.tok_len = p.tok_len + 1'b1;
      end
      return q;
   endfunction

   function automatic parse_type parse_step(parse_type p, byte_type c);
      parse_type q;
      q = p;
      case (p.phase)
         PH_LEAD: begin
            if (c == CH_NUL) begin
               q.phase = PH_DONE;
            end else if (!is_space(c)) begin
               q       = match_char(p, c);
               q.phase = PH_TOKEN;
            end
         end
         PH_TOKEN: begin
            if (is_space(c)) begin
               q.phase = PH_SEP;
            end else if (c == CH_NUL) begin
               q.phase = PH_DONE;
            end else begin
               q = match_char(p, c);
            end
         end
         PH_SEP: begin
            if (is_space(c)) begin
               q.phase = PH_SEP;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
               q.phase = PH_SIGNED;
               q.neg   = (c == CH_MINUS);
            end else if (is_digit(c)) begin
               q.phase  = PH_DIGITS;
               q.digits = 1'b1;
               q.val    = c - CH_ZERO;
            end else begin
               q.phase = PH_DONE;
            end
         end
         PH_SIGNED: begin
            if (is_digit(c)) begin
               q.phase  = PH_DIGITS;
               q.digits = 1'b1;
               q.val    = c - CH_ZERO;
            end else begin
               q.phase = PH_DONE;
            end
         end
         PH_DIGITS: begin
            if (is_digit(c)) begin
               q.val = sat_digit(p.val, c);
            end else begin
               q.phase = PH_DONE;
            end
         end
         default: begin
            q.phase = PH_DONE;
         end
      endcase
      return q;
   endfunction

   function automatic byte_type parse_number(parse_type p);
      byte_type r;
      if (!p.digits) begin
         r = NUM_NONE;
      end else if (p.neg && p.val != '0) begin
         r = NUM_SAT;
      end else if (p.val > NUM_SAT) begin
         r = NUM_SAT;
      end else begin
         r = p.val;
      end
      return r;
   endfunction

endpackage

[hdl/erc_req_if.sv]
// ----------------------------------------------------------------------------
// erc_req_if
// Request channel: start beats and received reply bytes.
// ----------------------------------------------------------------------------
interface erc_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   erc_pkg::kind_type  kind;
   erc_pkg::byte_type  rx_byte;

   modport source (output valid, output mode, output kind, output rx_byte, input ready);
   modport sink   (input valid, input mode, input kind, input rx_byte, output ready);
endinterface

[hdl/erc_rsp_if.sv]
// ----------------------------------------------------------------------------
// erc_rsp_if
// Response channel: reply status and extracted controller fields.
// ----------------------------------------------------------------------------
interface erc_rsp_if;
   logic                 valid;
   logic                 ready;
   erc_pkg::status_type  status;
   logic                 byte_skipped;
   erc_pkg::byte_type    boot_revision;
   erc_pkg::byte_type    boot_pin;
   erc_pkg::word_type    mcu_word;
   erc_pkg::byte_type    fw_revision;
   erc_pkg::byte_type    fw_patch;
   erc_pkg::byte_type    input_setting;
   erc_pkg::byte_type    telem_setting;
   erc_pkg::byte_type    telem_ident;

   modport source (
      output valid, output status, output byte_skipped, output boot_revision,
      output boot_pin, output mcu_word, output fw_revision, output fw_patch,
      output input_setting, output telem_setting, output telem_ident,
      input ready
   );
   modport sink (
      input valid, input status, input byte_skipped, input boot_revision,
      input boot_pin, input mcu_word, input fw_revision, input fw_patch,
      input input_setting, input telem_setting, input telem_ident,
      output ready
   );
endinterface

[hdl/esc_response_checker_top.sv]
// ----------------------------------------------------------------------------
// esc_response_checker_top
// Checks bootloader reply bytes: status pair, count pair, crc-32 over the
// payload, text lines, and keeps the fields pulled out of good replies.
// ----------------------------------------------------------------------------
// timing: a response beat is valid in the cycle after its request is taken
// throughput: one request beat per cycle unless a response stalls; the crc and
//   text parser take one byte per beat; each reply is judged on its last byte
// reset: synchronous; reply idle, index zero, crc all ones, fields zero
// ----------------------------------------------------------------------------
module esc_response_checker_top (
   input  logic      clock,
   input  logic      reset,
   erc_req_if.sink   req_bus,
   erc_rsp_if.source rsp_bus
);
   import erc_pkg::*;

   reply_state_type state_ff, state_in;
   index_type       index_ff, index_in;
   logic            skip_ff, skip_in;
   logic            skipped_ff, skipped_in;
   word_type        crc_ff, crc_in;
   parse_type       parse_ff, parse_in;
   byte_type        cap_ff [CAPTURE_BYTES];
   byte_type        cap_in [CAPTURE_BYTES];
   logic [HIST_W-1:0] hist_ff, hist_in;
   byte_type        boot_rev_ff, boot_rev_in;
   byte_type        boot_pin_ff, boot_pin_in;
   word_type        mcu_ff, mcu_in;
   byte_type        fw_rev_ff, fw_rev_in;
   byte_type        fw_patch_ff, fw_patch_in;
   byte_type        input_set_ff, input_set_in;
   byte_type        telem_set_ff, telem_set_in;
   byte_type        telem_id_ff, telem_id_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic            req_acc;
   byte_type        b;
   logic            stored;
   word_type        rx_crc;
   logic            crc_match;
   byte_type        line_num;

   assign req_acc       = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign b             = req_bus.rx_byte;
   assign stored        = index_ff < index_type'(STORE_BYTES);
   assign rx_crc        = {b, hist_ff};
   assign line_num      = parse_number(parse_ff);

   always_comb begin
      state_in     = state_ff;
      index_in     = index_ff;
      skip_in      = skip_ff;
      skipped_in   = skipped_ff;
      crc_in       = crc_ff;
      parse_in     = parse_ff;
      cap_in       = cap_ff;
      hist_in      = hist_ff;
      boot_rev_in  = boot_rev_ff;
      boot_pin_in  = boot_pin_ff;
      mcu_in       = mcu_ff;
      fw_rev_in    = fw_rev_ff;
      fw_patch_in  = fw_patch_ff;
      input_set_in = input_set_ff;
      telem_set_in = telem_set_ff;
      telem_id_in  = telem_id_ff;
      crc_match    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      if (req_acc) begin
         rsp_valid_in = 1'b1;
         skipped_in   = 1'b0;
         if (req_bus.mode == MODE_START) begin
            state_in = kind_state(req_bus.kind);
            index_in = '0;
            skip_in  = 1'b1;
            crc_in   = CRC_INIT;
            parse_in = PARSE_RESET;
         end else if (skip_ff) begin
            skip_in    = 1'b0;
            skipped_in = 1'b1;
         end else begin
            if (stored) begin
               index_in = index_ff + 1'b1;
               hist_in  = {b, hist_ff[HIST_W-1:8]};
               if (index_ff < index_type'(CAPTURE_BYTES)) begin
                  cap_in[index_ff[CAP_IDX_W-1:0]] = b;
               end
               if ((state_ff == RS_INFO && index_ff >= index_type'(PAYLOAD_START) &&
                    index_ff < index_type'(INFO_CRC_END)) ||
                   (state_ff == RS_READ && index_ff >= index_type'(PAYLOAD_START) &&
                    index_ff < index_type'(READ_CRC_END))) begin
                  crc_in = crc_byte(crc_ff, b);
               end
            end
            crc_match = (~crc_in) == rx_crc;

            case (state_ff)
               RS_PROBE, RS_WRITE, RS_BWRITE: begin
                  if (index_in == index_type'(BIN_END)) begin
                     state_in = pair_ok(cap_in[0], cap_in[1], STATUS_OK) ? RS_OK : RS_ERROR;
                  end
               end
               RS_INFO: begin
                  if (index_in == index_type'(INFO_END)) begin
                     if (pair_ok(cap_in[0], cap_in[1], INFO_COUNT) && crc_match) begin
                        boot_rev_in = cap_in[2];
                        boot_pin_in = cap_in[3];
                        mcu_in      = {cap_in[7], cap_in[6], cap_in[5], cap_in[4]};
                        state_in    = RS_OK;
                     end else begin
                        state_in = RS_ERROR;
                     end
                  end
               end
               RS_READ: begin
                  if (index_in == index_type'(READ_END)) begin
                     if (pair_ok(cap_in[0], cap_in[1], READ_COUNT) && crc_match &&
                         cap_in[2] == READ_TAG0 && cap_in[3] == READ_TAG1) begin
                        fw_rev_in   = cap_in[4];
                        fw_patch_in = cap_in[5];
                        state_in    = RS_OK;
                     end else begin
                        state_in = RS_ERROR;
                     end
                  end
               end
               RS_TEXT: begin
                  if (index_ff < index_type'(LINE_END)) begin
                     parse_in = parse_step(parse_ff, b);
                  end
                  if (b == CH_LF) begin
                     if (index_in == index_type'(OK_END)) begin
                        state_in = (cap_in[0] == CH_O && cap_in[1] == CH_K) ? RS_OK : RS_ERROR;
                     end else if (index_in == index_type'(LINE_END) &&
                                  parse_ff.tok_len != '0) begin
                        if (parse_ff.hit_input && parse_ff.tok_len >= TOK_W'(KW_INPUT_LEN)) begin
                           input_set_in = line_num;
                        end else if (parse_ff.hit_telem &&
                                     parse_ff.tok_len >= TOK_W'(KW_TELEM_LEN)) begin
                           telem_set_in = line_num;
                        end else if (parse_ff.hit_phid &&
                                     parse_ff.tok_len >= TOK_W'(KW_PHID_LEN)) begin
                           telem_id_in = line_num;
                        end
                     end
                     index_in = '0;
                     parse_in = PARSE_RESET;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= RS_IDLE;
         index_ff     <= '0;
         skip_ff      <= 1'b0;
         skipped_ff   <= 1'b0;
         crc_ff       <= CRC_INIT;
         parse_ff     <= PARSE_RESET;
         boot_rev_ff  <= '0;
         boot_pin_ff  <= '0;
         mcu_ff       <= '0;
         fw_rev_ff    <= '0;
         fw_patch_ff  <= '0;
         input_set_ff <= '0;
         telem_set_ff <= '0;
         telem_id_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         index_ff     <= index_in;
         skip_ff      <= skip_in;
         skipped_ff   <= skipped_in;
         crc_ff       <= crc_in;
         parse_ff     <= parse_in;
         boot_rev_ff  <= boot_rev_in;
         boot_pin_ff  <= boot_pin_in;
         mcu_ff       <= mcu_in;
         fw_rev_ff    <= fw_rev_in;
         fw_patch_ff  <= fw_patch_in;
         input_set_ff <= input_set_in;
         telem_set_ff <= telem_set_in;
         telem_id_ff  <= telem_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff  <= cap_in;
      hist_ff <= hist_in;
   end

   always_comb begin
      case (state_ff)
         RS_IDLE:  rsp_bus.status = ST_IDLE;
         RS_OK:    rsp_bus.status = ST_OK;
         RS_ERROR: rsp_bus.status = ST_ERR;
         default:  rsp_bus.status = ST_WAIT;
      endcase
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.byte_skipped  = skipped_ff;
   assign rsp_bus.boot_revision = boot_rev_ff;
   assign rsp_bus.boot_pin      = boot_pin_ff;
   assign rsp_bus.mcu_word      = mcu_ff;
   assign rsp_bus.fw_revision   = fw_rev_ff;
   assign rsp_bus.fw_patch      = fw_patch_ff;
   assign rsp_bus.input_setting = input_set_ff;
   assign rsp_bus.telem_setting = telem_set_ff;
   assign rsp_bus.telem_ident   = telem_id_ff;

   // a start beat rearms the skip and rewinds the index
   a_start_rearms: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_bus.mode == MODE_START |=> skip_ff && index_ff == '0)
      else $error("start beat did not rearm skip");

   // the skipped beat leaves the reply state alone
   a_skip_only: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_bus.mode == MODE_BYTE && skip_ff |=>
         skipped_ff && !skip_ff && $stable(state_ff) && $stable(index_ff))
      else $error("skipped beat changed reply state");

   // a settled reply stays settled and keeps its fields
   a_settled: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_bus.mode == MODE_BYTE && !skip_ff &&
         (state_ff == RS_OK || state_ff == RS_ERROR) |=>
         $stable(state_ff) && $stable(mcu_ff) && $stable(fw_rev_ff) && $stable(telem_id_ff))
      else $error("settled reply changed");

   // the index never runs past the store
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      index_ff <= index_type'(STORE_BYTES))
      else $error("byte index beyond store");

   // a waiting response beat holds back new requests
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |-> !req_bus.ready)
      else $error("request taken while response stalled");

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bootloader reply checker. Start beats and reply
// bytes go in through the request channel. A shadow copy of the reply tracker
// (store, index, crc, parser, kept fields) predicts every response beat, and
// each beat is compared field by field. Covered: probe, write and bootloader
// write status pairs, info and read replies with count pair and crc, text
// lines, undefined kinds, a full store, settled replies, random and
// back-pressured traffic.
// ----------------------------------------------------------------------------
module tb_top;
   import erc_pkg::*;

   localparam int CYCLE_LIMIT   = 400_000;
   localparam int HOLD_CYCLES   = 240;
   localparam int DRAIN_LIMIT   = 4_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PRINT_CAP     = 60;
   localparam int PHASE_BEATS   = 140;

   localparam kind_type KIND_SPARE6 = 3'd6;
   localparam kind_type KIND_SPARE7 = 3'd7;

   localparam int SET_INPUT = 0;
   localparam int SET_TELEM = 1;
   localparam int SET_PHID  = 2;

   localparam int FLAW_NONE     = 0;
   localparam int FLAW_COUNT    = 1;
   localparam int FLAW_PAIR     = 2;
   localparam int FLAW_CRC      = 3;
   localparam int FLAW_TAG      = 4;
   localparam int FLAW_NO_COUNT = 5;

   typedef struct {
      status_type status;
      logic       skipped;
      byte_type   boot_revision;
      byte_type   boot_pin;
      word_type   mcu_word;
      byte_type   fw_revision;
      byte_type   fw_patch;
      byte_type   input_setting;
      byte_type   telem_setting;
      byte_type   telem_ident;
   } report_type;

   logic clock = 1'b0;
   logic reset;

   erc_req_if req_bus ();
   erc_rsp_if rsp_bus ();

   esc_response_checker_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow of the reply tracker
   byte_type        line_store [STORE_BYTES];
   int              fill_index;
   reply_state_type reply_phase;
   logic            discard_next;
   word_type        crc_acc;
   logic [47:0]     boot_info;
   logic [15:0]     fw_info;
   byte_type        settings [3];

   report_type due_reports [$];
   byte_type   outgoing [$];

   int cycle_count  = 0;
   int mismatches   = 0;
   int results_seen = 0;
   int beats_sent   = 0;
   int replies_sent = 0;
   int idle_pct     = 0;
   int stall_pct    = 0;
   int hold_asks    = 0;
   int hold_done    = 0;
   int hold_left    = 0;

   task automatic clear_shadow();
      foreach (line_store[i]) line_store[i] = '0;
      fill_index   = 0;
      reply_phase  = RS_IDLE;
      discard_next = 1'b0;
      crc_acc      = CRC_INIT;
      boot_info    = '0;
      fw_info      = '0;
      foreach (settings[i]) settings[i] = '0;
   endtask

   function automatic word_type crc_next(word_type c, byte_type b);
      word_type r;
      r = c ^ {24'h0, b};
      repeat (8) r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
      return r;
   endfunction

   function automatic logic is_blank(byte_type c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
             c == CH_FF || c == CH_CR;
   endfunction

   function automatic logic is_numeral(byte_type c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   // telemetry identifier keyword as text
   function automatic string phid_text();
      return $sformatf("%s", KW_PHID);
   endfunction

   function automatic byte_type count_pair();
      return ((line_store[0] ^ line_store[1]) == PAIR_BAD) ? line_store[0] : PAIR_BAD;
   endfunction

   function automatic logic payload_ok(int len);
      byte_type n;
      word_type got;
      n   = count_pair();
      got = {line_store[len + 5], line_store[len + 4], line_store[len + 3],
             line_store[len + 2]};
      if (n == PAIR_BAD || (int'(n) + 1) * 4 != len) return 1'b0;
      return ~crc_acc == got;
   endfunction

   function automatic logic token_has(int at, int len, string kw);
      if (len < kw.len()) return 1'b0;
      for (int j = 0; j < kw.len(); j++) begin
         if (line_store[at + j] != byte_type'(kw[j])) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void parse_text_line();
      int   stop, i, from, len, val, slot;
      logic neg, seen;
      stop = 0;
      i    = 0;
      val  = 0;
      neg  = 1'b0;
      seen = 1'b0;
      slot = -1;
      while (stop < LINE_END && line_store[stop] != CH_NUL) stop++;
      while (i < stop && is_blank(line_store[i])) i++;
      from = i;
      while (i < stop && !is_blank(line_store[i])) i++;
      len = i - from;
      if (token_has(from, len, "input_m")) slot = SET_INPUT;
      else if (token_has(from, len, "telem_m")) slot = SET_TELEM;
      else if (token_has(from, len, phid_text())) slot = SET_PHID;
      if (slot < 0) return;
      while (i < stop && is_blank(line_store[i])) i++;
      if (i < stop && (line_store[i] == CH_PLUS || line_store[i] == CH_MINUS)) begin
         neg = line_store[i] == CH_MINUS;
         i++;
      end
      while (i < stop && is_numeral(line_store[i])) begin
         val = val * 10 + int'(line_store[i]) - int'(CH_ZERO);
         if (val > int'(NUM_SAT)) val = int'(NUM_NONE);
         seen = 1'b1;
         i++;
      end
      if (!seen) settings[slot] = NUM_NONE;
      else if (neg && val != 0) settings[slot] = NUM_SAT;
      else settings[slot] = (val > int'(NUM_SAT)) ? NUM_SAT : byte_type'(val);
   endfunction

   function automatic void take_byte(byte_type b);
      int pos, plen;
      pos  = fill_index;
      plen = (reply_phase == RS_INFO) ? INFO_PAYLOAD : READ_PAYLOAD;
      if (pos < STORE_BYTES) begin
         line_store[pos] = b;
         fill_index      = pos + 1;
         if ((reply_phase == RS_INFO || reply_phase == RS_READ) &&
             pos >= PAYLOAD_START && pos < PAYLOAD_START + plen) begin
            crc_acc = crc_next(crc_acc, b);
         end
      end
      case (reply_phase)
         RS_PROBE, RS_WRITE, RS_BWRITE: begin
            if (fill_index == BIN_END) begin
               reply_phase = (count_pair() == STATUS_OK) ? RS_OK : RS_ERROR;
            end
         end
         RS_INFO: begin
            if (fill_index == INFO_END) begin
               if (payload_ok(INFO_PAYLOAD)) begin
                  boot_info   = {line_store[7], line_store[6], line_store[5],
                                 line_store[4], line_store[3], line_store[2]};
                  reply_phase = RS_OK;
               end else begin
                  reply_phase = RS_ERROR;
               end
            end
         end
         RS_READ: begin
            if (fill_index == READ_END) begin
               if (payload_ok(READ_PAYLOAD) && line_store[2] == READ_TAG0 &&
                   line_store[3] == READ_TAG1) begin
                  fw_info     = {line_store[5], line_store[4]};
                  reply_phase = RS_OK;
               end else begin
                  reply_phase = RS_ERROR;
               end
            end
         end
         RS_TEXT: begin
            if (b == CH_LF) begin
               if (fill_index == OK_END) begin
                  reply_phase = (line_store[0] == CH_O && line_store[1] == CH_K &&
                                 line_store[2] == CH_LF) ? RS_OK : RS_ERROR;
               end else if (fill_index == LINE_END) begin
                  parse_text_line();
               end
               fill_index = 0;
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic report_type track_reply(logic mode, kind_type kind, byte_type b);
      report_type r;
      r.skipped = 1'b0;
      if (mode == MODE_START) begin
         case (kind)
            KIND_PROBE:  reply_phase = RS_PROBE;
            KIND_INFO:   reply_phase = RS_INFO;
            KIND_READ:   reply_phase = RS_READ;
            KIND_WRITE:  reply_phase = RS_WRITE;
            KIND_BWRITE: reply_phase = RS_BWRITE;
            KIND_TEXT:   reply_phase = RS_TEXT;
            default:     reply_phase = RS_IDLE;
         endcase
         fill_index   = 0;
         discard_next = 1'b1;
         crc_acc      = CRC_INIT;
      end else if (discard_next) begin
         discard_next = 1'b0;
         r.skipped    = 1'b1;
      end else begin
         take_byte(b);
      end
      case (reply_phase)
         RS_IDLE:  r.status = ST_IDLE;
         RS_OK:    r.status = ST_OK;
         RS_ERROR: r.status = ST_ERR;
         default:  r.status = ST_WAIT;
      endcase
      r.boot_revision = boot_info[7:0];
      r.boot_pin      = boot_info[15:8];
      r.mcu_word      = boot_info[47:16];
      r.fw_revision   = fw_info[7:0];
      r.fw_patch      = fw_info[15:8];
      r.input_setting = settings[SET_INPUT];
      r.telem_setting = settings[SET_TELEM];
      r.telem_ident   = settings[SET_PHID];
      return r;
   endfunction

   // checking

   task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= PRINT_CAP) begin
         $display("cycle %0d result %0d: %s is %0h, expected %0h",
                  cycle_count, results_seen, what, got, want);
      end
   endtask

   task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want) note_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin : result_check
      report_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
         results_seen++;
         if (due_reports.size() == 0) begin
            note_mismatch("result with nothing awaited", '0, '0);
         end else begin
            want = due_reports.pop_front();
            check_field("status", 64'(rsp_bus.status), 64'(want.status));
            check_field("byte_skipped", 64'(rsp_bus.byte_skipped), 64'(want.skipped));
            check_field("boot_revision", 64'(rsp_bus.boot_revision),
                        64'(want.boot_revision));
            check_field("boot_pin", 64'(rsp_bus.boot_pin), 64'(want.boot_pin));
            check_field("mcu_word", 64'(rsp_bus.mcu_word), 64'(want.mcu_word));
            check_field("fw_revision", 64'(rsp_bus.fw_revision), 64'(want.fw_revision));
            check_field("fw_patch", 64'(rsp_bus.fw_patch), 64'(want.fw_patch));
            check_field("input_setting", 64'(rsp_bus.input_setting),
                        64'(want.input_setting));
            check_field("telem_setting", 64'(rsp_bus.telem_setting),
                        64'(want.telem_setting));
            check_field("telem_ident", 64'(rsp_bus.telem_ident), 64'(want.telem_ident));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, due_reports.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: random stalls plus an occasional long hold-off
   initial begin : receiver
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else if (hold_asks != hold_done) begin
            hold_done++;
            hold_left     = HOLD_CYCLES;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = $urandom_range(99) >= stall_pct;
         end
      end
   end

   // sending

   task automatic send_beat(logic mode, kind_type kind, byte_type b);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid   = 1'b1;
      req_bus.mode    = mode;
      req_bus.kind    = kind;
      req_bus.rx_byte = b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      due_reports.push_back(track_reply(mode, kind, b));
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic send_start(kind_type kind);
      send_beat(MODE_START, kind, byte_type'($urandom_range(255)));
   endtask

   task automatic send_byte(byte_type b);
      send_beat(MODE_BYTE, kind_type'($urandom_range(7)), b);
   endtask

   task automatic send_reply(kind_type kind);
      send_start(kind);
      send_byte(byte_type'($urandom_range(255)));
      foreach (outgoing[i]) send_byte(outgoing[i]);
      outgoing.delete();
      replies_sent++;
   endtask

   // reply builders

   task automatic add_pair(byte_type a, byte_type b);
      outgoing.push_back(a);
      outgoing.push_back(b);
   endtask

   task automatic add_status_pair(logic good);
      byte_type a;
      a = byte_type'($urandom_range(1, 255));
      if (good) add_pair(STATUS_OK, ~STATUS_OK);
      else case ($urandom_range(2))
         0:       add_pair(a, ~a);
         1:       add_pair(STATUS_OK, ~STATUS_OK ^ a);
         default: add_pair(byte_type'($urandom_range(255)), byte_type'($urandom_range(255)));
      endcase
   endtask

   task automatic add_payload_reply(kind_type kind, int flaw);
      byte_type count, good_count;
      byte_type body [$];
      word_type crc;
      int       plen;
      good_count = (kind == KIND_INFO) ? INFO_COUNT : READ_COUNT;
      plen       = (kind == KIND_INFO) ? INFO_PAYLOAD : READ_PAYLOAD;
      count      = good_count;
      crc        = CRC_INIT;
      for (int i = 0; i < plen; i++) body.push_back(byte_type'($urandom_range(255)));
      if (kind == KIND_READ) begin
         body[0] = READ_TAG0;
         body[1] = READ_TAG1;
      end
      if (flaw == FLAW_TAG) body[$urandom_range(1)] ^= byte_type'($urandom_range(1, 255));
      foreach (body[i]) crc = crc_next(crc, body[i]);
      crc = ~crc;
      case (flaw)
         FLAW_COUNT: begin
            count = byte_type'($urandom_range(255));
            if (count == good_count) count = count ^ 8'h01;
         end
         FLAW_CRC:      crc = crc ^ (word_type'(1) << $urandom_range(31));
         FLAW_NO_COUNT: count = PAIR_BAD;
         default: begin
         end
      endcase
      outgoing.push_back(count);
      if (flaw == FLAW_PAIR) outgoing.push_back(~count ^ byte_type'($urandom_range(1, 255)));
      else outgoing.push_back(~count);
      foreach (body[i]) outgoing.push_back(body[i]);
      for (int k = 0; k < CRC_BYTES; k++) outgoing.push_back(crc[8*k +: 8]);
   endtask

   // a 14-byte line: text cut or padded to 13 characters, then a newline
   task automatic add_padded_line(string s, logic with_nul);
      int base;
      if (s.len() > LINE_END - 1) s = s.substr(0, LINE_END - 2);
      while (s.len() < LINE_END - 1) begin
         if ($urandom_range(3) == 0) s = {s, "z"};
         else s = {s, " "};
      end
      base = outgoing.size();
      for (int i = 0; i < s.len(); i++) outgoing.push_back(byte_type'(s[i]));
      if (with_nul) outgoing[base + $urandom_range(LINE_END - 2)] = CH_NUL;
      outgoing.push_back(CH_LF);
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) outgoing.push_back(byte_type'(s[i]));
   endtask

   function automatic string pick_word();
      case ($urandom_range(7))
         0:       return "input_m";
         1:       return "input_mux";
         2:       return "telem_m";
         3:       return "telem_mask";
         4:       return phid_text();
         5:       return "telem_ph";
         6:       return "output_m";
         default: return "x";
      endcase
   endfunction

   function automatic int pick_number();
      case ($urandom_range(3))
         0:       return $urandom_range(9);
         1:       return $urandom_range(253, 256);
         2:       return $urandom_range(999);
         default: return $urandom_range(99999);
      endcase
   endfunction

   task automatic add_setting_line();
      string s;
      int    r;
      s = "";
      repeat ($urandom_range(2)) begin
         if ($urandom_range(1)) s = {s, " "};
         else s = {s, "\t"};
      end
      s = {s, pick_word()};
      r = $urandom_range(9);
      if (r < 6) s = {s, " "};
      else if (r < 8) s = {s, "\t "};
      r = $urandom_range(9);
      if (r == 0) s = {s, "-"};
      else if (r == 1) s = {s, "+"};
      r = $urandom_range(9);
      if (r < 7) s = {s, $sformatf("%0d", pick_number())};
      else if (r == 7) s = {s, "00", $sformatf("%0d", pick_number())};
      add_padded_line(s, $urandom_range(9) == 0);
   endtask

   task automatic add_text_lines(logic clean);
      int r;
      repeat ($urandom_range(1, 3)) begin
         r = $urandom_range(99);
         if (clean) begin
            if (r < 25) add_text("OK\n");
            else add_setting_line();
         end else if (r < 20) begin
            add_text("OK\n");
         end else if (r < 35) begin
            outgoing.push_back(byte_type'($urandom_range(255)));
            outgoing.push_back(byte_type'($urandom_range(255)));
            outgoing.push_back(CH_LF);
         end else if (r < 65) begin
            add_setting_line();
         end else begin
            repeat ($urandom_range(r < 90 ? 0 : 20, r < 90 ? 18 : 70))
               outgoing.push_back(byte_type'($urandom_range(255)));
            outgoing.push_back(CH_LF);
         end
      end
   endtask

   task automatic build_reply(kind_type kind, logic clean);
      case (kind)
         KIND_INFO, KIND_READ: begin
            add_payload_reply(kind, clean ? FLAW_NONE : $urandom_range(FLAW_COUNT, FLAW_NO_COUNT));
         end
         KIND_TEXT: add_text_lines(clean);
         default:   add_status_pair(clean ? $urandom_range(3) != 0 : $urandom_range(3) == 0);
      endcase
   endtask

   task automatic send_random_reply();
      int       r, cut;
      kind_type kind;
      r    = $urandom_range(99);
      kind = kind_type'($urandom_range(KIND_TEXT));
      if (r < 85) begin
         build_reply(kind, r < 70);
         if (r >= 70 && $urandom_range(1)) begin
            cut = $urandom_range(outgoing.size());
            while (outgoing.size() > cut) void'(outgoing.pop_back());
         end
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 8)) outgoing.push_back(byte_type'($urandom_range(255)));
         end
         send_reply(kind);
      end else if ($urandom_range(3) == 0) begin
         // stray bytes on top of whatever reply is open
         repeat ($urandom_range(1, 6)) send_byte(byte_type'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(12)) outgoing.push_back(byte_type'($urandom_range(255)));
         send_reply(kind_type'($urandom_range(7)));
      end
   endtask

   // tests

   task automatic test_binary_replies();
      add_status_pair(1'b1);
      send_reply(KIND_PROBE);
      add_pair(8'h01, 8'hfe);
      send_reply(KIND_WRITE);
      add_pair(STATUS_OK, 8'hfe);
      send_reply(KIND_BWRITE);
      add_pair(STATUS_OK, ~STATUS_OK);
      add_pair(8'hff, 8'h00);
      send_reply(KIND_BWRITE);
      add_pair(STATUS_OK, ~STATUS_OK);
      send_reply(KIND_SPARE6);
      add_pair(8'hff, 8'hff);
      send_reply(KIND_SPARE7);
      // a second start while the skip is still armed
      send_start(KIND_WRITE);
      add_status_pair(1'b1);
      send_reply(KIND_WRITE);
   endtask

   task automatic test_info_replies();
      add_payload_reply(KIND_INFO, FLAW_NONE);
      send_reply(KIND_INFO);
      add_payload_reply(KIND_INFO, FLAW_CRC);
      send_reply(KIND_INFO);
      add_payload_reply(KIND_INFO, FLAW_NO_COUNT);
      send_reply(KIND_INFO);
      // settled reply running past the end of the store
      add_payload_reply(KIND_INFO, FLAW_NONE);
      repeat (30) outgoing.push_back(byte_type'($urandom_range(255)));
      send_reply(KIND_INFO);
   endtask

   task automatic test_read_replies();
      add_payload_reply(KIND_READ, FLAW_NONE);
      send_reply(KIND_READ);
      add_payload_reply(KIND_READ, FLAW_TAG);
      send_reply(KIND_READ);
      add_payload_reply(KIND_READ, FLAW_COUNT);
      send_reply(KIND_READ);
      add_payload_reply(KIND_READ, FLAW_PAIR);
      send_reply(KIND_READ);
   endtask

   task automatic test_text_replies();
      add_padded_line("input_m 300", 1'b0);
      add_padded_line("telem_m -5", 1'b0);
      add_padded_line(phid_text(), 1'b0);
      add_padded_line(" telem_m +0", 1'b0);
      add_padded_line({phid_text(), " 17"}, 1'b0);
      add_padded_line("input_m 254", 1'b1);
      add_text("OK\n");
      send_reply(KIND_TEXT);
      add_text("NO\n");
      send_reply(KIND_TEXT);
      // long line fills the store before its newline arrives
      repeat (70) outgoing.push_back(8'h61);
      outgoing.push_back(CH_LF);
      add_padded_line("input_m 12", 1'b0);
      add_text("OK\n");
      send_reply(KIND_TEXT);
   endtask

   task automatic test_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      hold_asks++;
      repeat (3) begin
         add_payload_reply(KIND_INFO, FLAW_NONE);
         send_reply(KIND_INFO);
      end
   endtask

   task automatic test_random_replies(int idle, int stall, int beats);
      int target;
      idle_pct  = idle;
      stall_pct = stall;
      target    = beats_sent + beats;
      while (beats_sent < target) send_random_reply();
   endtask

   initial begin
      int drain;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.mode    = MODE_START;
      req_bus.kind    = KIND_PROBE;
      req_bus.rx_byte = '0;
      clear_shadow();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_binary_replies();
      test_info_replies();
      test_read_replies();
      test_text_replies();
      test_backpressure();
      test_random_replies(0, 0, PHASE_BEATS);
      test_random_replies(87, 0, PHASE_BEATS);
      test_random_replies(0, 87, PHASE_BEATS);
      test_random_replies(30, 30, PHASE_BEATS);

      req_bus.valid = 1'b0;
      idle_pct      = 0;
      stall_pct     = 0;
      drain         = 0;
      while (due_reports.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (due_reports.size() != 0) begin
         note_mismatch("results never delivered", 64'(due_reports.size()), '0);
      end

      $display("covered %0d replies over %0d request beats, %0d results checked",
               replies_sent, beats_sent, results_seen);
      $display("binary, info, read, text and undefined kinds; four idle mixes and a long hold");
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
